### rtl/ramped_move_controller_top_defines.svh
// assertion macros for the ramped move controller
// used by ramped_move_controller_top.sv, needs no other file
`ifndef RAMPED_MOVE_CONTROLLER_TOP_DEFINES_SVH
`define RAMPED_MOVE_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rmc_pkg.sv
// shared constants for the ramped move controller
// no dependencies; used by rmc_if.sv and ramped_move_controller_top.sv
package rmc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int TIME_W          = 32;
    localparam int ENC_W           = 32;
    localparam int PWR_W           = 7;
    localparam int OUT_W           = 8;
    localparam int DIST_W          = 16;
    // shared subtractor width, holds 100 * (elapsed + 1)
    localparam int SUB_W           = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_POWER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_DIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PWR  = 3'd6;

    localparam logic [1:0] AXIS_STRAFE = 2'd1;
    localparam logic [1:0] AXIS_ROTATE = 2'd2;

    localparam logic [DIST_W-1:0] RAMP_MS_RST   = 16'd2000;
    localparam logic [DIST_W-1:0] SLOW_DIST_RST = 16'd400;
    localparam logic [PWR_W-1:0]  SLOW_PWR_RST  = 7'd30;
    localparam logic [PWR_W-1:0]  POWER_MAX     = 7'd100;

endpackage

### rtl/rmc_if.sv
// handshake channels of the ramped move controller: sample, power and config
// depends on rmc_pkg
interface rmc_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [rmc_pkg::TIME_W-1:0]           now_ms;
    logic signed [rmc_pkg::ENC_W-1:0]     enc_left;
    logic signed [rmc_pkg::ENC_W-1:0]     enc_right;

    modport source (output valid, action, now_ms, enc_left, enc_right, input ready);
    modport sink   (input valid, action, now_ms, enc_left, enc_right, output ready);
endinterface

interface rmc_pwr_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmc_pkg::OUT_W-1:0]     front_left;
    logic signed [rmc_pkg::OUT_W-1:0]     back_left;
    logic signed [rmc_pkg::OUT_W-1:0]     front_right;
    logic signed [rmc_pkg::OUT_W-1:0]     back_right;
    logic                                 done_res;

    modport source (output valid, front_left, back_left, front_right, back_right, done_res,
                    input ready);
    modport sink   (input valid, front_left, back_left, front_right, back_right, done_res,
                    output ready);
endinterface

interface rmc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rmc_pkg::CFG_IDX_W-1:0]        index;
    logic [rmc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ramped_move_controller_top.sv
// ramped move controller: sequencer around one shared subtract/compare unit
// depends on rmc_pkg, rmc_if.sv and ramped_move_controller_top_defines.svh
//
// channel | modport | payload
// --------+---------+-----------------------------------------------------
// cmd     | sink    | action, now_ms, enc_left, enc_right
// pwr     | source  | front_left, back_left, front_right, back_right, done_res
// cfg     | sink    | index, data (register write, always ready)
//
// a tick while finished goes straight to the output step, a tick that reaches
// the target stops after the target check, an active tick runs the steps up to
// the output step, and the ramp divide adds one setup step and 7 quotient steps
// each step is a sequencer state; most steps use the shared 40-bit subtractor
// cmd.ready is high only while the sequencer idles; a full result register
// stalls the sequencer at its last step until pwr.ready
// async active-low reset: no result valid, move finished, config at defaults
`include "ramped_move_controller_top_defines.svh"

module ramped_move_controller_top #(
    parameter int COUNT_WIDTH = rmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rmc_cmd_if.sink    cmd,
    rmc_pwr_if.source  pwr,
    rmc_cfg_if.sink    cfg
);

    localparam int SW = rmc_pkg::SUB_W;
    localparam int PW = rmc_pkg::PWR_W;
    localparam int DW = rmc_pkg::DIST_W;
    localparam int TW = rmc_pkg::TIME_W;
    localparam int OW = rmc_pkg::OUT_W;
    localparam int NST = 17;

    // one-hot sequencer states
    typedef enum logic [NST-1:0] {
        ST_IDLE = NST'(1) << 0,
        ST_DIFL = NST'(1) << 1,   // left encoder change
        ST_NEGL = NST'(1) << 2,   // left magnitude
        ST_DIFR = NST'(1) << 3,
        ST_NEGR = NST'(1) << 4,
        ST_MAXC = NST'(1) << 5,   // larger change is the distance
        ST_TGTC = NST'(1) << 6,   // target reached check
        ST_REMS = NST'(1) << 7,   // remaining ticks
        ST_ELAP = NST'(1) << 8,   // elapsed ms
        ST_MULE = NST'(1) << 9,   // 100 * (elapsed + 1)
        ST_MULP = NST'(1) << 10,  // target_power * ramp_ms
        ST_TTFC = NST'(1) << 11,  // still ramping check
        ST_DIVS = NST'(1) << 12,  // dividend = 100 * elapsed
        ST_DIVI = NST'(1) << 13,  // one quotient bit per cycle
        ST_ZONE = NST'(1) << 14,  // slow zone check
        ST_CAPC = NST'(1) << 15,  // slow cap compare
        ST_OUTP = NST'(1) << 16   // mix and load result
    } state_t;

    // ---------------- configuration registers ----------------
    logic [1:0]    axis_reg;
    logic          rev_reg;
    logic [PW-1:0] tpow_reg;
    logic [DW-1:0] tdist_reg;
    logic [DW-1:0] ramp_reg;
    logic [DW-1:0] sdist_reg;
    logic [PW-1:0] spow_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= '0;
            rev_reg   <= 1'b0;
            tpow_reg  <= '0;
            tdist_reg <= '0;
            ramp_reg  <= rmc_pkg::RAMP_MS_RST;
            sdist_reg <= rmc_pkg::SLOW_DIST_RST;
            spow_reg  <= rmc_pkg::SLOW_PWR_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rmc_pkg::CFG_AXIS:      axis_reg  <= cfg.data[1:0];
                rmc_pkg::CFG_REVERSE:   rev_reg   <= cfg.data[0];
                rmc_pkg::CFG_TGT_POWER: tpow_reg  <= cfg.data[PW-1:0];
                rmc_pkg::CFG_TGT_DIST:  tdist_reg <= cfg.data;
                rmc_pkg::CFG_RAMP_MS:   ramp_reg  <= cfg.data;
                rmc_pkg::CFG_SLOW_DIST: sdist_reg <= cfg.data;
                rmc_pkg::CFG_SLOW_PWR:  spow_reg  <= cfg.data[PW-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // power registers above 100 saturate
    logic [PW-1:0] tgt_pw;
    logic [PW-1:0] cap_pw;
    assign tgt_pw = (tpow_reg > rmc_pkg::POWER_MAX) ? rmc_pkg::POWER_MAX : tpow_reg;
    assign cap_pw = (spow_reg > rmc_pkg::POWER_MAX) ? rmc_pkg::POWER_MAX : spow_reg;

    // ---------------- state ----------------
    state_t state_reg, state_next;
    logic   fin_reg, fin_next;         // move finished or never started
    logic   done_reg, done_next;       // result of this request is the done result
    logic   ramping_reg, ramping_next; // inside the ramp phase
    logic   zone_reg, zone_next;       // inside the slow zone
    logic [2:0] cnt_reg, cnt_next;     // quotient bit position, 6 down to 0

    // move baseline
    logic [TW-1:0]          start_reg, start_next;
    logic [COUNT_WIDTH-1:0] lbase_reg, lbase_next;
    logic [COUNT_WIDTH-1:0] rbase_reg, rbase_next;

    // per-request working registers
    logic [TW-1:0]          now_reg, now_next;
    logic [COUNT_WIDTH-1:0] el_reg, el_next;
    logic [COUNT_WIDTH-1:0] er_reg, er_next;
    logic [COUNT_WIDTH-1:0] dl_reg, dl_next;
    logic [COUNT_WIDTH-1:0] dr_reg, dr_next;
    logic [COUNT_WIDTH-1:0] trav_reg, trav_next;
    logic [DW-1:0]          remain_reg, remain_next;
    logic [TW-1:0]          elap_reg, elap_next;
    logic [SW-1:0]          acc_reg, acc_next;   // 100*(e+1), then division remainder
    logic [SW-1:0]          prod_reg, prod_next; // target_power * ramp_ms
    logic [PW-1:0]          pw_reg, pw_next;     // unsigned power, also the quotient

    // result register
    logic                 ovalid_reg, ovalid_next;
    logic signed [OW-1:0] fl_reg, fl_next;
    logic signed [OW-1:0] bl_reg, bl_next;
    logic signed [OW-1:0] fr_reg, fr_next;
    logic signed [OW-1:0] br_reg, br_next;
    logic                 odone_reg, odone_next;

    // ---------------- shared subtract / compare unit ----------------
    logic [SW-1:0] sub_a;
    logic [SW-1:0] sub_b;
    logic [SW:0]   sub_full;
    logic [SW-1:0] sub_diff;
    logic          sub_borrow;

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            ST_DIFL:
            begin
                sub_a = SW'(el_reg);
                sub_b = SW'(lbase_reg);
            end
            ST_NEGL: sub_b = SW'(dl_reg);
            ST_DIFR:
            begin
                sub_a = SW'(er_reg);
                sub_b = SW'(rbase_reg);
            end
            ST_NEGR: sub_b = SW'(dr_reg);
            ST_MAXC:
            begin
                sub_a = SW'(dl_reg);
                sub_b = SW'(dr_reg);
            end
            ST_TGTC:
            begin
                sub_a = SW'(trav_reg);
                sub_b = SW'(tdist_reg);
            end
            ST_REMS:
            begin
                sub_a = SW'(tdist_reg);
                sub_b = SW'(trav_reg);
            end
            ST_ELAP:
            begin
                sub_a = SW'(now_reg);
                sub_b = SW'(start_reg);
            end
            ST_TTFC:
            begin
                sub_a = prod_reg;
                sub_b = acc_reg;
            end
            ST_DIVS:
            begin
                sub_a = acc_reg;
                sub_b = SW'(rmc_pkg::POWER_MAX);
            end
            ST_DIVI:
            begin
                sub_a = acc_reg;
                sub_b = SW'(ramp_reg) << cnt_reg;
            end
            ST_ZONE:
            begin
                sub_a = SW'(sdist_reg);
                sub_b = SW'(remain_reg);
            end
            ST_CAPC:
            begin
                sub_a = SW'(cap_pw);
                sub_b = SW'(pw_reg);
            end
            ST_IDLE, ST_MULE, ST_MULP, ST_OUTP: ;
            default: ;
        endcase
        sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
        sub_diff   = sub_full[SW-1:0];
        sub_borrow = sub_full[SW];
    end

    // ---------------- sequencer ----------------
    logic                 cmd_take;
    logic                 out_free;
    logic signed [OW-1:0] p_pos;
    logic signed [OW-1:0] p_neg;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign out_free  = !ovalid_reg || pwr.ready;

    always_comb
    begin
        p_pos = rev_reg ? -$signed({1'b0, pw_reg}) : $signed({1'b0, pw_reg});
        p_neg = -p_pos;
    end

    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        done_next    = done_reg;
        ramping_next = ramping_reg;
        zone_next    = zone_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        lbase_next   = lbase_reg;
        rbase_next   = rbase_reg;
        now_next     = now_reg;
        el_next      = el_reg;
        er_next      = er_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        trav_next    = trav_reg;
        remain_next  = remain_reg;
        elap_next    = elap_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        pw_next      = pw_reg;
        ovalid_next  = ovalid_reg && !pwr.ready;
        fl_next      = fl_reg;
        bl_next      = bl_reg;
        fr_next      = fr_reg;
        br_next      = br_reg;
        odone_next   = odone_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    now_next = cmd.now_ms;
                    el_next  = cmd.enc_left[COUNT_WIDTH-1:0];
                    er_next  = cmd.enc_right[COUNT_WIDTH-1:0];
                    if (cmd.action)
                    begin
                        // start request: this sample becomes the baseline
                        start_next = cmd.now_ms;
                        lbase_next = cmd.enc_left[COUNT_WIDTH-1:0];
                        rbase_next = cmd.enc_right[COUNT_WIDTH-1:0];
                        fin_next   = 1'b0;
                    end
                    if (cmd.action || !fin_reg)
                    begin
                        done_next  = 1'b0;
                        state_next = ST_DIFL;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_OUTP;
                    end
                end
            end
            ST_DIFL:
            begin
                dl_next    = sub_diff[COUNT_WIDTH-1:0];
                state_next = ST_NEGL;
            end
            ST_NEGL:
            begin
                // most negative change maps to 2^(COUNT_WIDTH-1) unsigned
                if (dl_reg[COUNT_WIDTH-1])
                    dl_next = sub_diff[COUNT_WIDTH-1:0];
                state_next = ST_DIFR;
            end
            ST_DIFR:
            begin
                dr_next    = sub_diff[COUNT_WIDTH-1:0];
                state_next = ST_NEGR;
            end
            ST_NEGR:
            begin
                if (dr_reg[COUNT_WIDTH-1])
                    dr_next = sub_diff[COUNT_WIDTH-1:0];
                state_next = ST_MAXC;
            end
            ST_MAXC:
            begin
                trav_next  = sub_borrow ? dr_reg : dl_reg;
                state_next = ST_TGTC;
            end
            ST_TGTC:
            begin
                if (!sub_borrow)
                begin
                    // distance reached
                    fin_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_OUTP;
                end
                else
                    state_next = ST_REMS;
            end
            ST_REMS:
            begin
                remain_next = sub_diff[DW-1:0];
                state_next  = ST_ELAP;
            end
            ST_ELAP:
            begin
                elap_next  = sub_diff[TW-1:0];
                state_next = ST_MULE;
            end
            ST_MULE:
            begin
                // constant multiply, shift-add in synthesis
                acc_next   = SW'(elap_reg) * SW'(rmc_pkg::POWER_MAX)
                             + SW'(rmc_pkg::POWER_MAX);
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                prod_next  = SW'(tgt_pw) * SW'(ramp_reg);
                state_next = ST_TTFC;
            end
            ST_TTFC:
            begin
                // elapsed < floor(P/100)  <=>  100*(elapsed+1) <= P
                // ramp_ms of zero gives P = 0, so the full power applies at once
                ramping_next = !sub_borrow;
                if (!sub_borrow)
                    state_next = ST_DIVS;
                else
                begin
                    pw_next    = tgt_pw;
                    state_next = ST_ZONE;
                end
            end
            ST_DIVS:
            begin
                acc_next   = sub_diff;
                pw_next    = '0;
                cnt_next   = 3'(PW - 1);
                state_next = ST_DIVI;
            end
            ST_DIVI:
            begin
                // quotient stays below target_power, so seven bits cover it
                if (!sub_borrow)
                begin
                    acc_next         = sub_diff;
                    pw_next[cnt_reg] = 1'b1;
                end
                if (cnt_reg == '0)
                    state_next = ST_ZONE;
                else
                    cnt_next = cnt_reg - 3'd1;
            end
            ST_ZONE:
            begin
                zone_next  = !sub_borrow;
                state_next = ST_CAPC;
            end
            ST_CAPC:
            begin
                if (zone_reg && sub_borrow)
                    pw_next = cap_pw;
                state_next = ST_OUTP;
            end
            ST_OUTP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odone_next  = done_reg;
                    if (done_reg)
                    begin
                        fl_next = '0;
                        bl_next = '0;
                        fr_next = '0;
                        br_next = '0;
                    end
                    else
                    begin
                        unique case (axis_reg)
                            rmc_pkg::AXIS_STRAFE:
                            begin
                                fl_next = p_pos;
                                bl_next = p_neg;
                                fr_next = p_neg;
                                br_next = p_pos;
                            end
                            rmc_pkg::AXIS_ROTATE:
                            begin
                                fl_next = p_pos;
                                bl_next = p_pos;
                                fr_next = p_neg;
                                br_next = p_neg;
                            end
                            default:
                            begin
                                // forward/back, also the unused axis code
                                fl_next = p_pos;
                                bl_next = p_pos;
                                fr_next = p_pos;
                                br_next = p_pos;
                            end
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fin_reg    <= 1'b1;
            ovalid_reg <= 1'b0;
            start_reg  <= '0;
            lbase_reg  <= '0;
            rbase_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
            start_reg  <= start_next;
            lbase_reg  <= lbase_next;
            rbase_reg  <= rbase_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        done_reg    <= done_next;
        ramping_reg <= ramping_next;
        zone_reg    <= zone_next;
        cnt_reg     <= cnt_next;
        now_reg     <= now_next;
        el_reg      <= el_next;
        er_reg      <= er_next;
        dl_reg      <= dl_next;
        dr_reg      <= dr_next;
        trav_reg    <= trav_next;
        remain_reg  <= remain_next;
        elap_reg    <= elap_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        pw_reg      <= pw_next;
        fl_reg      <= fl_next;
        bl_reg      <= bl_next;
        fr_reg      <= fr_next;
        br_reg      <= br_next;
        odone_reg   <= odone_next;
    end

    assign pwr.valid       = ovalid_reg;
    assign pwr.front_left  = fl_reg;
    assign pwr.back_left   = bl_reg;
    assign pwr.front_right = fr_reg;
    assign pwr.back_right  = br_reg;
    assign pwr.done_res    = odone_reg;

    // ---------------- assertions ----------------
    logic done_out;
    logic pwr_all_zero;
    logic start_take;
    logic move_open;
    logic mix_ramp;
    logic pw_in_range;

    assign done_out     = pwr.valid && pwr.done_res;
    assign pwr_all_zero = (pwr.front_left == '0) && (pwr.back_left == '0)
                          && (pwr.front_right == '0) && (pwr.back_right == '0);
    assign start_take   = cmd_take && cmd.action;
    assign move_open    = !fin_reg && (state_reg == ST_DIFL);
    assign mix_ramp     = (state_reg == ST_OUTP) && !done_reg && ramping_reg;
    assign pw_in_range  = (pw_reg <= rmc_pkg::POWER_MAX);

    // one request at a time: no new request right after one is taken
    `RMC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, cmd_take, !cmd.ready, "request taken while busy")
    // a done result carries zero powers
    `RMC_ASSERT_NOW(a_done_zero, clk, rst_n, done_out, pwr_all_zero, "done with nonzero power")
    // start request always opens an active move
    `RMC_ASSERT_NEXT(a_start_clears, clk, rst_n, start_take, move_open, "start request ignored")
    // while ramping, the commanded power never exceeds full scale
    `RMC_ASSERT_NOW(a_power_range, clk, rst_n, mix_ramp, pw_in_range, "ramp quotient too large")

endmodule
